// ===== hw/rtl/rmwf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rmwf_pkg
// Shared constants and codes for the RGB median window filter.
// ----------------------------------------------------------------------------
package rmwf_pkg;

   localparam int RADIUS_DEFAULT    = 1;
   localparam int MAX_WIDTH_DEFAULT = 1024;

   localparam int CFG_WIDTH_BITS  = 11;
   localparam int CFG_HEIGHT_BITS = 16;
   localparam int CSR_ADDR_BITS   = 3;
   localparam int CSR_DATA_BITS   = 32;

   localparam logic [CFG_WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd1024;
   localparam logic [CFG_HEIGHT_BITS-1:0] HEIGHT_RESET = 16'd1024;

   localparam int CHAN_BITS   = 8;
   localparam int PIX_BITS    = 3 * CHAN_BITS;
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_FLUSH = 1'b1
   } opcode_type;

   typedef enum logic {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } reg_index_type;

endpackage
`default_nettype wire

// ===== hw/rtl/rmwf_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rmwf_fifo
// Short register queue between the front and back ends.
// ----------------------------------------------------------------------------
module rmwf_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = rmwf_pkg::QUEUE_DEPTH
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         push,
   input  wire logic [WIDTH-1:0]             push_data,
   input  wire logic                         pop,
   output logic                              not_empty,
   output logic [WIDTH-1:0]                  head_data,
   output logic [$clog2(DEPTH+1)-1:0]        count
);
   localparam int PW = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH+1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH-1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH-1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign not_empty = (count_ff != '0);
   assign head_data = slot_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/rmwf_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rmwf_front
// Accepts pixels, tracks frame positions, writes the line stores and
// gathers one clamped window column per fetch into the queue.
// ----------------------------------------------------------------------------
module rmwf_front #(
   parameter int RADIUS    = rmwf_pkg::RADIUS_DEFAULT,
   parameter int MAX_WIDTH = rmwf_pkg::MAX_WIDTH_DEFAULT
) (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   input  wire logic                                        restart,
   input  wire logic [$clog2(MAX_WIDTH+1)-1:0]              width,
   input  wire logic [rmwf_pkg::CFG_HEIGHT_BITS-1:0]        height,
   input  wire logic                                        req_valid,
   output logic                                             req_stall,
   input  wire logic                                        req_opcode,
   input  wire logic [rmwf_pkg::PIX_BITS-1:0]               req_pixel,
   input  wire logic [$clog2(rmwf_pkg::QUEUE_DEPTH+1)-1:0]  q_count,
   output logic                                             push_valid,
   output logic [(2*RADIUS+1)*(rmwf_pkg::PIX_BITS+$clog2(2*RADIUS+1))+1:0]
                                                            push_data
);
   localparam int DIAM  = 2*RADIUS + 1;
   localparam int BW    = $clog2(DIAM);
   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int WW    = $clog2(MAX_WIDTH+1);
   localparam int HW    = rmwf_pkg::CFG_HEIGHT_BITS;
   localparam int TW    = WW + HW;
   localparam int NW    = TW + 1;
   localparam int PIX   = rmwf_pkg::PIX_BITS;
   localparam int QD    = rmwf_pkg::QUEUE_DEPTH;
   localparam int QCW   = $clog2(QD+1);

   logic [NW-1:0] n_ff, n_in;
   logic [CW-1:0] wcol_ff, wcol_in;
   logic [BW-1:0] wbank_ff, wbank_in;
   logic [CW-1:0] fcol_ff, fcol_in;
   logic [HW-1:0] frow_ff, frow_in;
   logic [BW-1:0] fbank_ff, fbank_in;
   logic [CW-1:0] ocol_ff, ocol_in;
   logic [HW-1:0] orow_ff, orow_in;

   logic [TW-1:0] total;
   logic [TW-1:0] fetch_start;
   logic [TW-1:0] lag;
   logic [CW-1:0] col_last;
   logic          accept, in_frame, take, do_fetch, do_out, is_last, wr_en;

   logic          f1_valid_ff, f1_out_ff, f1_last_ff;
   logic [BW-1:0] f1_sel_ff  [DIAM];
   logic [BW-1:0] f1_bank_ff [DIAM];
   logic [DIAM-1:0] f1_in_ff;
   logic [PIX-1:0] f1_pix_ff;

   logic [BW-1:0] src_bank [DIAM];
   logic [DIAM-1:0] src_in;
   logic [BW-1:0] col_sel [DIAM];
   logic [PIX-1:0] rd_data [DIAM];

   assign total       = TW'(height) * TW'(width);
   assign fetch_start = TW'(width) * TW'(RADIUS);
   assign lag         = fetch_start + TW'(RADIUS);
   assign col_last    = CW'(width - WW'(1));

   assign req_stall = ((QCW+1)'(q_count) + (QCW+1)'(f1_valid_ff)) >= (QCW+1)'(QD);
   assign accept    = req_valid && !req_stall;
   assign in_frame  = n_ff < NW'(total);
   // flush ticks before the frame is complete are dropped
   assign take      = accept && !(in_frame && (req_opcode == rmwf_pkg::OP_FLUSH));
   assign wr_en     = take && in_frame;
   assign do_fetch  = take && (n_ff >= NW'(fetch_start));
   assign do_out    = take && (n_ff >= NW'(lag));
   assign is_last   = do_out && (orow_ff == height - HW'(1)) && (ocol_ff == col_last);

   always_comb begin
      n_in     = n_ff;
      wcol_in  = wcol_ff;
      wbank_in = wbank_ff;
      fcol_in  = fcol_ff;
      frow_in  = frow_ff;
      fbank_in = fbank_ff;
      ocol_in  = ocol_ff;
      orow_in  = orow_ff;
      if (take) begin
         n_in = n_ff + NW'(1);
         if (wcol_ff == col_last) begin
            wcol_in  = '0;
            wbank_in = (wbank_ff == BW'(DIAM-1)) ? '0 : wbank_ff + BW'(1);
         end else begin
            wcol_in = wcol_ff + CW'(1);
         end
      end
      if (do_fetch) begin
         if (fcol_ff == col_last) begin
            fcol_in  = '0;
            frow_in  = frow_ff + HW'(1);
            fbank_in = (fbank_ff == BW'(DIAM-1)) ? '0 : fbank_ff + BW'(1);
         end else begin
            fcol_in = fcol_ff + CW'(1);
         end
      end
      if (do_out) begin
         if (ocol_ff == col_last) begin
            ocol_in = '0;
            orow_in = orow_ff + HW'(1);
         end else begin
            ocol_in = ocol_ff + CW'(1);
         end
      end
      if (restart || is_last) begin
         n_in     = '0;
         wcol_in  = '0;
         wbank_in = '0;
         fcol_in  = '0;
         frow_in  = '0;
         fbank_in = '0;
         ocol_in  = '0;
         orow_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff        <= '0;
         wcol_ff     <= '0;
         wbank_ff    <= '0;
         fcol_ff     <= '0;
         frow_ff     <= '0;
         fbank_ff    <= '0;
         ocol_ff     <= '0;
         orow_ff     <= '0;
         f1_valid_ff <= 1'b0;
      end else begin
         n_ff        <= n_in;
         wcol_ff     <= wcol_in;
         wbank_ff    <= wbank_in;
         fcol_ff     <= fcol_in;
         frow_ff     <= frow_in;
         fbank_ff    <= fbank_in;
         ocol_ff     <= ocol_in;
         orow_ff     <= orow_in;
         f1_valid_ff <= do_fetch;
      end
   end

   // one line store per row bank (row mod DIAM); the newest row comes from the input
   for (genvar b = 0; b < DIAM; b++) begin : g_bank
      logic [PIX-1:0] mem [MAX_WIDTH];
      logic [PIX-1:0] mem_rd_ff;
      always_ff @(posedge clock) begin
         if (wr_en && (wbank_ff == BW'(b))) begin
            mem[wcol_ff] <= req_pixel;
         end
         mem_rd_ff <= mem[fcol_ff];
      end
      assign rd_data[b] = mem_rd_ff;
   end

   // vertical clamp: pick the bank holding each window row
   for (genvar i = 0; i < DIAM; i++) begin : g_row
      localparam int OFF = (i >= RADIUS) ? (i - RADIUS) : (i - RADIUS + DIAM);
      logic [HW:0]   row_sum;
      logic          at_top, at_bottom;
      logic [HW-1:0] below;
      logic [BW:0]   bsum, bred;
      assign row_sum   = {1'b0, frow_ff} + (HW+1)'(i);
      assign at_top    = row_sum < (HW+1)'(RADIUS);
      assign at_bottom = row_sum >= ({1'b0, height} + (HW+1)'(RADIUS));
      assign below     = height - HW'(1) - frow_ff;
      always_comb begin
         if (at_bottom) begin
            bsum = {1'b0, fbank_ff} + below[BW:0];
         end else begin
            bsum = {1'b0, fbank_ff} + (BW+1)'(OFF);
         end
         bred = (bsum >= (BW+1)'(DIAM)) ? bsum - (BW+1)'(DIAM) : bsum;
         if (at_top || (bred >= (BW+1)'(DIAM))) begin
            src_bank[i] = '0;
         end else begin
            src_bank[i] = bred[BW-1:0];
         end
      end
      assign src_in[i] = !at_top && !at_bottom && (i == DIAM-1);
   end

   // horizontal clamp: which held column feeds each window column
   for (genvar k = 0; k < DIAM; k++) begin : g_col
      logic [WW:0]   c_sum;
      logic [WW-1:0] right_dist;
      logic [CW-1:0] left_dist;
      assign c_sum      = (WW+1)'(ocol_ff) + (WW+1)'(k);
      assign left_dist  = CW'(RADIUS) - ocol_ff;
      assign right_dist = width - WW'(ocol_ff) - WW'(1) + WW'(RADIUS);
      always_comb begin
         if (c_sum < (WW+1)'(RADIUS)) begin
            col_sel[k] = BW'(left_dist);
         end else if (c_sum >= ((WW+1)'(width) + (WW+1)'(RADIUS))) begin
            col_sel[k] = BW'(right_dist);
         end else begin
            col_sel[k] = BW'(k);
         end
      end
   end

   always_ff @(posedge clock) begin
      f1_out_ff  <= do_out;
      f1_last_ff <= is_last;
      f1_in_ff   <= src_in;
      f1_pix_ff  <= req_pixel;
      for (int e = 0; e < DIAM; e++) begin
         f1_sel_ff[e]  <= col_sel[e];
         f1_bank_ff[e] <= src_bank[e];
      end
   end

   always_comb begin
      push_data = '0;
      for (int e = 0; e < DIAM; e++) begin
         push_data[e*PIX +: PIX] = f1_in_ff[e] ? f1_pix_ff : rd_data[f1_bank_ff[e]];
         push_data[DIAM*PIX + e*BW +: BW] = f1_sel_ff[e];
      end
      push_data[DIAM*(PIX+BW)]     = f1_out_ff;
      push_data[DIAM*(PIX+BW) + 1] = f1_last_ff;
   end

   assign push_valid = f1_valid_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/rmwf_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rmwf_back
// Holds the last window columns, builds each window and finds the
// per-channel median by rank counting over a short pipeline.
// ----------------------------------------------------------------------------
module rmwf_back #(
   parameter int RADIUS = rmwf_pkg::RADIUS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              q_valid,
   input  wire logic [(2*RADIUS+1)*(rmwf_pkg::PIX_BITS+$clog2(2*RADIUS+1))+1:0]
                                                  q_data,
   output logic                                   q_pop,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [rmwf_pkg::CHAN_BITS-1:0]         rsp_out_blue,
   output logic [rmwf_pkg::CHAN_BITS-1:0]         rsp_out_green,
   output logic [rmwf_pkg::CHAN_BITS-1:0]         rsp_out_red,
   output logic                                   rsp_frame_last
);
   localparam int DIAM = 2*RADIUS + 1;
   localparam int BW   = $clog2(DIAM);
   localparam int N    = DIAM * DIAM;
   localparam int MID  = N / 2;
   localparam int CNW  = $clog2(N+1);
   localparam int PIX  = rmwf_pkg::PIX_BITS;
   localparam int CH   = rmwf_pkg::CHAN_BITS;

   logic advance;

   logic [PIX-1:0] span_ff [DIAM][DIAM];   // [column][row], highest column newest

   logic          b0_valid_ff, b0_last_ff;
   logic [BW-1:0] b0_sel_ff [DIAM];

   logic          b1_valid_ff, b1_last_ff;
   logic [CH-1:0] b1_val_ff [3][N];
   logic [N-1:0]  b1_lt_ff  [3][N];

   logic          b2_valid_ff, b2_last_ff;
   logic [CH-1:0] b2_val_ff [3][N];
   logic [N-1:0]  b2_hit_ff [3];

   logic          rsp_valid_ff, rsp_last_ff;
   logic [CH-1:0] rsp_chan_ff [3];

   logic [CH-1:0] win_val [3][N];
   logic [N-1:0]  lt_mat  [3][N];
   logic [N-1:0]  hit     [3];
   logic [CH-1:0] median  [3];

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign q_pop   = q_valid && advance;

   always_ff @(posedge clock) begin
      if (q_pop) begin
         for (int j = 0; j < DIAM-1; j++) begin
            for (int i = 0; i < DIAM; i++) begin
               span_ff[j][i] <= span_ff[j+1][i];
            end
         end
         for (int i = 0; i < DIAM; i++) begin
            span_ff[DIAM-1][i] <= q_data[i*PIX +: PIX];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_valid_ff  <= 1'b0;
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         b0_valid_ff  <= q_pop && q_data[DIAM*(PIX+BW)];
         b1_valid_ff  <= b0_valid_ff;
         b2_valid_ff  <= b1_valid_ff;
         rsp_valid_ff <= b2_valid_ff;
      end
   end

   // window gather and pairwise compares
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         for (int i = 0; i < DIAM; i++) begin
            for (int k = 0; k < DIAM; k++) begin
               win_val[c][i*DIAM+k] = span_ff[b0_sel_ff[k]][i][c*CH +: CH];
            end
         end
         for (int a = 0; a < N; a++) begin
            for (int b = 0; b < N; b++) begin
               lt_mat[c][a][b] = win_val[c][b] < win_val[c][a];
            end
         end
      end
   end

   // element a is the median when its rank range covers the middle index
   always_comb begin
      logic [CNW-1:0] less;
      logic [CNW-1:0] greater;
      for (int c = 0; c < 3; c++) begin
         for (int a = 0; a < N; a++) begin
            less    = '0;
            greater = '0;
            for (int b = 0; b < N; b++) begin
               less    = less + CNW'(b1_lt_ff[c][a][b]);
               greater = greater + CNW'(b1_lt_ff[c][b][a]);
            end
            hit[c][a] = (less <= CNW'(MID)) && (greater < CNW'(N - MID));
         end
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         median[c] = '0;
         for (int a = 0; a < N; a++) begin
            median[c] = median[c] | (b2_val_ff[c][a] & {CH{b2_hit_ff[c][a]}});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < DIAM; k++) begin
            b0_sel_ff[k] <= q_data[DIAM*PIX + k*BW +: BW];
         end
         b0_last_ff  <= q_data[DIAM*(PIX+BW) + 1];
         b1_last_ff  <= b0_last_ff;
         b2_last_ff  <= b1_last_ff;
         rsp_last_ff <= b2_last_ff;
         for (int c = 0; c < 3; c++) begin
            b1_val_ff[c]   <= win_val[c];
            b1_lt_ff[c]    <= lt_mat[c];
            b2_val_ff[c]   <= b1_val_ff[c];
            b2_hit_ff[c]   <= hit[c];
            rsp_chan_ff[c] <= median[c];
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_blue   = rsp_chan_ff[0];
   assign rsp_out_green  = rsp_chan_ff[1];
   assign rsp_out_red    = rsp_chan_ff[2];
   assign rsp_frame_last = rsp_last_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/rgb_median_window_filter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_median_window_filter
// Streaming per-channel median over a clamped square window of BGR pixels.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  opcode, pixel blue/green/red
//   rsp      out        rsp_valid / rsp_stall  median blue/green/red, frame_last
//   csr      in         APB-style write/read   image_width, image_height
//
// One item per clock while no stall holds; the line stores give one window
// column per clock and the rank-count median runs as a pipeline.
// A result passes the fetch register, the queue and the b0, b1, b2 and rsp registers.
// Synchronous reset clears counters and valids; line stores are not cleared.
// req_stall rises when the 4-entry queue plus the item in flight fill up.
// ----------------------------------------------------------------------------
module rgb_median_window_filter #(
   parameter int RADIUS    = rmwf_pkg::RADIUS_DEFAULT,
   parameter int MAX_WIDTH = rmwf_pkg::MAX_WIDTH_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,

   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic                                  req_opcode,
   input  wire logic [rmwf_pkg::CHAN_BITS-1:0]        req_pixel_blue,
   input  wire logic [rmwf_pkg::CHAN_BITS-1:0]        req_pixel_green,
   input  wire logic [rmwf_pkg::CHAN_BITS-1:0]        req_pixel_red,

   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic [rmwf_pkg::CHAN_BITS-1:0]             rsp_out_blue,
   output logic [rmwf_pkg::CHAN_BITS-1:0]             rsp_out_green,
   output logic [rmwf_pkg::CHAN_BITS-1:0]             rsp_out_red,
   output logic                                       rsp_frame_last,

   input  wire logic                                  csr_psel,
   input  wire logic                                  csr_penable,
   input  wire logic                                  csr_pwrite,
   input  wire logic [rmwf_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  wire logic [rmwf_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [rmwf_pkg::CSR_DATA_BITS-1:0]         csr_prdata,
   output logic                                       csr_pready
);
   localparam int DIAM = 2*RADIUS + 1;
   localparam int BW   = $clog2(DIAM);
   localparam int EW   = DIAM * (rmwf_pkg::PIX_BITS + BW) + 2;
   localparam int WW   = $clog2(MAX_WIDTH+1);
   localparam int CWB  = rmwf_pkg::CFG_WIDTH_BITS;
   localparam int CHB  = rmwf_pkg::CFG_HEIGHT_BITS;
   localparam int QD   = rmwf_pkg::QUEUE_DEPTH;
   localparam int DW   = rmwf_pkg::CSR_DATA_BITS;

   logic [CWB-1:0] width_ff, width_in;
   logic [CHB-1:0] height_ff, height_in;
   logic           csr_write;
   logic           restart;
   logic [WW-1:0]  width_eff;
   logic [CHB-1:0] height_eff;

   logic                    push_valid;
   logic [EW-1:0]           push_data;
   logic                    q_not_empty;
   logic [EW-1:0]           q_head;
   logic                    q_pop;
   logic [$clog2(QD+1)-1:0] q_count;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign restart    = csr_write;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            rmwf_pkg::REG_IMAGE_WIDTH:  width_in  = csr_pwdata[CWB-1:0];
            rmwf_pkg::REG_IMAGE_HEIGHT: height_in = csr_pwdata[CHB-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= rmwf_pkg::WIDTH_RESET;
         height_ff <= rmwf_pkg::HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   always_comb begin
      case (csr_paddr[2])
         rmwf_pkg::REG_IMAGE_WIDTH:  csr_prdata = DW'(width_ff);
         rmwf_pkg::REG_IMAGE_HEIGHT: csr_prdata = DW'(height_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   // zero means one; width saturates at the line store size
   always_comb begin
      if (width_ff == '0) begin
         width_eff = WW'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         width_eff = WW'(MAX_WIDTH);
      end else begin
         width_eff = WW'(width_ff);
      end
      height_eff = (height_ff == '0) ? CHB'(1) : height_ff;
   end

   rmwf_front #(
      .RADIUS    (RADIUS),
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .restart    (restart),
      .width      (width_eff),
      .height     (height_eff),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .req_pixel  ({req_pixel_red, req_pixel_green, req_pixel_blue}),
      .q_count    (q_count),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   rmwf_fifo #(
      .WIDTH (EW),
      .DEPTH (QD)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (push_data),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_data (q_head),
      .count     (q_count)
   );

   rmwf_back #(
      .RADIUS (RADIUS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_not_empty),
      .q_data         (q_head),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_blue   (rsp_out_blue),
      .rsp_out_green  (rsp_out_green),
      .rsp_out_red    (rsp_out_red),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule
`default_nettype wire
